### src/pia_pkg.sv
// Shared constants, types and codes for the positional array with insert and delete.
package pia_pkg;

    localparam int CAPACITY = 64;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = 7;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2
    } pia_cmd_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_BAD_POS   = 3'd2,
        ST_DELETED   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_ENTRY     = 3'd5,
        ST_EMPTY     = 3'd6
    } pia_status_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_READ
    } pia_state_t;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic                    insert_en;
        logic                    delete_en;
        logic                    rotate_en;
        logic [CNT_W-1:0]        position;
        logic [CNT_W-1:0]        count;
        logic signed [VAL_W-1:0] value;
    } pia_ctl_t;

endpackage

### src/pia_in_if.sv
// Command channel: valid/ready handshake carrying one command word.
interface pia_in_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       command;
    logic signed [pia_pkg::VAL_W-1:0] value;
    logic [pia_pkg::CNT_W-1:0]        position;

    modport source (output valid, output command, output value, output position,
                    input ready);
    modport sink (input valid, input command, input value, input position,
                  output ready);
endinterface

### src/pia_out_if.sv
// Result channel: valid/ready handshake carrying one result word.
interface pia_out_if;
    logic                             valid;
    logic                             ready;
    pia_pkg::pia_status_t             status;
    logic signed [pia_pkg::VAL_W-1:0] entry_value;
    logic [pia_pkg::CNT_W-1:0]        entry_index;
    logic [pia_pkg::CNT_W-1:0]        count;
    logic                             last;

    modport source (output valid, output status, output entry_value, output entry_index,
                    output count, output last, input ready);
    modport sink (input valid, input status, input entry_value, input entry_index,
                  input count, input last, output ready);
endinterface

### src/positional_array_insert_delete.sv
// Top level: packed array of signed 32-bit entries kept in a chain of cells.
//
// Commands arrive on the request channel and results leave on the result
// channel, both valid/ready; a word moves at a rising edge with both high.
// For insert and delete, every cell compares or shifts in parallel, and the
// single result word is shown by the output register in the cycle after the
// command is taken. Readout of n entries first enters the read state, then
// gives one result word per cycle while the output register is free, by
// rotating the held entries through cell 0; the chain is back in its
// original order after the last word. Readout of an empty array gives a
// single empty status word. Command code 3 is taken and gives no result.
// A new command is taken only while no readout is running and the output
// register is free or being emptied in the same cycle. When the receiver
// stalls, the output register holds its word and readout pauses.
// Reset clears the count, the control state and the output valid; the
// entry storage is not cleared and is read only where it was written.
module positional_array_insert_delete (
    input  logic      clk,
    input  logic      rst_n,
    pia_in_if.sink    request,
    pia_out_if.source result
);
    import pia_pkg::*;

    pia_state_t              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        rd_idx_reg, rd_idx_next;
    logic                    out_valid_reg, out_valid_next;
    pia_status_t             out_status_reg, out_status_next;
    logic signed [VAL_W-1:0] out_value_reg, out_value_next;
    logic [CNT_W-1:0]        out_index_reg, out_index_next;
    logic [CNT_W-1:0]        out_count_reg, out_count_next;
    logic                    out_last_reg, out_last_next;

    pia_ctl_t                ctl;
    logic                    slot_free;
    logic                    in_acc;
    logic                    load;
    logic                    ins_ok;
    logic                    found;
    logic                    rd_last;
    logic [CNT_W-1:0]        found_idx;
    logic [CAPACITY-1:0]     match_vec;
    logic [CAPACITY-1:0]     low_incl;
    logic [CAPACITY-1:0]     first_hit;
    logic [CAPACITY-1:0]     shift_vec;
    logic signed [VAL_W-1:0] cell_data [CAPACITY];

    // Cell chain.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VAL_W-1:0] lower_w;
        logic signed [VAL_W-1:0] upper_w;

        if (i == 0)
        begin : g_lo_end
            assign lower_w = '0;
        end
        else
        begin : g_lo
            assign lower_w = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_hi_end
            assign upper_w = '0;
        end
        else
        begin : g_hi
            assign upper_w = cell_data[i+1];
        end

        pia_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .my_index   (CNT_W'(i)),
            .lower      (lower_w),
            .upper      (upper_w),
            .head       (cell_data[0]),
            .shift_down (shift_vec[i]),
            .match      (match_vec[i]),
            .data       (cell_data[i])
        );
    end

    // Lowest matching cell: the subtract marks every bit up to the lowest set one.
    assign low_incl  = match_vec ^ (match_vec - CAPACITY'(1));
    assign first_hit = low_incl & match_vec;
    assign shift_vec = (~low_incl) | first_hit;
    assign found     = |match_vec;

    always_comb
    begin
        found_idx = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first_hit[i])
                found_idx = found_idx | CNT_W'(i);
        end
    end

    assign slot_free     = !out_valid_reg || result.ready;
    assign request.ready = (state_reg == FSM_IDLE) && slot_free;
    assign in_acc        = request.valid && request.ready;
    assign ins_ok        = (count_reg < CNT_W'(CAPACITY)) && (request.position <= count_reg);
    assign rd_last       = (rd_idx_reg + CNT_W'(1) == count_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (in_acc && request.command == CMD_READ && count_reg != '0)
                    state_next = FSM_READ;
            end
            FSM_READ:
            begin
                if (slot_free && rd_last)
                    state_next = FSM_IDLE;
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // Datapath control and result formation.
    always_comb
    begin
        ctl.insert_en   = 1'b0;
        ctl.delete_en   = 1'b0;
        ctl.rotate_en   = 1'b0;
        ctl.position    = request.position;
        ctl.count       = count_reg;
        ctl.value       = request.value;
        load            = 1'b0;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_index_next  = out_index_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            FSM_IDLE:
            begin
                rd_idx_next = '0;
                if (in_acc)
                begin
                    unique case (request.command)
                        CMD_INSERT:
                        begin
                            load           = 1'b1;
                            ctl.insert_en  = ins_ok;
                            out_value_next = request.value;
                            out_index_next = request.position;
                            out_last_next  = 1'b1;
                            if (count_reg == CNT_W'(CAPACITY))
                                out_status_next = ST_FULL;
                            else if (request.position > count_reg)
                                out_status_next = ST_BAD_POS;
                            else
                                out_status_next = ST_INSERTED;
                            if (ins_ok)
                                count_next = count_reg + CNT_W'(1);
                            out_count_next = count_next;
                        end
                        CMD_DELETE:
                        begin
                            load           = 1'b1;
                            ctl.delete_en  = found;
                            out_value_next = request.value;
                            out_last_next  = 1'b1;
                            if (found)
                            begin
                                out_status_next = ST_DELETED;
                                out_index_next  = found_idx;
                                count_next      = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                out_status_next = ST_NOT_FOUND;
                                out_index_next  = '0;
                            end
                            out_count_next = count_next;
                        end
                        CMD_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                load            = 1'b1;
                                out_status_next = ST_EMPTY;
                                out_value_next  = '0;
                                out_index_next  = '0;
                                out_count_next  = '0;
                                out_last_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                            load = 1'b0;
                        end
                    endcase
                end
            end
            FSM_READ:
            begin
                if (slot_free)
                begin
                    load            = 1'b1;
                    ctl.rotate_en   = 1'b1;
                    out_status_next = ST_ENTRY;
                    out_value_next  = cell_data[0];
                    out_index_next  = rd_idx_reg;
                    out_count_next  = count_reg;
                    out_last_next   = rd_last;
                    rd_idx_next     = rd_idx_reg + CNT_W'(1);
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase

        if (load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_index_reg  <= out_index_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.status      = out_status_reg;
    assign result.entry_value = out_value_reg;
    assign result.entry_index = out_index_reg;
    assign result.count       = out_count_reg;
    assign result.last        = out_last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_read_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == FSM_READ |-> rd_idx_reg < count_reg)
        else $error("readout index past the held entries");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && request.command == CMD_INSERT && ins_ok
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("accepted insert did not grow the count");

    a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && request.command == CMD_DELETE && found
        |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("successful delete did not shrink the count");

    a_read_no_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == FSM_READ |=> $stable(count_reg))
        else $error("count changed during readout");

endmodule

### src/pia_cell.sv
// One storage cell of the chain: holds an entry and shifts with its neighbors.
module pia_cell (
    input  logic                             clk,
    input  pia_pkg::pia_ctl_t                ctl,
    input  logic [pia_pkg::CNT_W-1:0]        my_index,
    input  logic signed [pia_pkg::VAL_W-1:0] lower,
    input  logic signed [pia_pkg::VAL_W-1:0] upper,
    input  logic signed [pia_pkg::VAL_W-1:0] head,
    input  logic                             shift_down,
    output logic                             match,
    output logic signed [pia_pkg::VAL_W-1:0] data
);
    import pia_pkg::*;

    logic signed [VAL_W-1:0] data_reg;
    logic signed [VAL_W-1:0] data_next;

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        data_next = data_reg;
        priority if (ctl.insert_en)
        begin
            if (my_index == ctl.position)
                data_next = ctl.value;
            else if (my_index > ctl.position && my_index <= ctl.count)
                data_next = lower;
        end
        else if (ctl.delete_en)
        begin
            if (shift_down)
                data_next = upper;
        end
        else if (ctl.rotate_en)
        begin
            // The held entries rotate toward index 0; the top one takes the head.
            if (my_index + CNT_W'(1) == ctl.count)
                data_next = head;
            else if (my_index < ctl.count)
                data_next = upper;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    assign match = (my_index < ctl.count) && (data_reg == ctl.value);
    assign data  = data_reg;

endmodule
